// ----- hdl/sha1bs_pkg.sv -----
// Shared types and constants for the SHA-1 byte stream hasher.
// Used by the round logic and the top level; depends on nothing.
`default_nettype none

package sha1bs_pkg;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} sha1bs_work_t;

	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam logic [31:0] K_ROUND [4] = '{
		32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [2:0] LAST_WORD_IDX = 3'd4;

endpackage

`default_nettype wire

// ----- hdl/sha1bs_round.sv -----
// One SHA-1 round: the logic function, round constant and the five-word update.
// Depends on sha1bs_pkg.
`default_nettype none

module sha1bs_round (
	input  var sha1bs_pkg::sha1bs_work_t cur,
	input  var logic [31:0]              wt,
	input  var logic [6:0]               rnd,
	output var sha1bs_pkg::sha1bs_work_t nxt
);
	import sha1bs_pkg::*;

	logic [1:0]  grp;
	logic [31:0] f;
	logic [31:0] k;

	always_comb begin
		if (rnd < 7'd20) begin
			grp = 2'd0;
		end else if (rnd < 7'd40) begin
			grp = 2'd1;
		end else if (rnd < 7'd60) begin
			grp = 2'd2;
		end else begin
			grp = 2'd3;
		end
	end

	always_comb begin
		case (grp)
			2'd0: f = (cur.b & cur.c) | (~cur.b & cur.d);
			2'd2: f = (cur.b & cur.c) ^ (cur.b & cur.d) ^ (cur.c & cur.d);
			default: f = cur.b ^ cur.c ^ cur.d;
		endcase
		k = K_ROUND[grp];
	end

	always_comb begin
		nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + wt + k;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

`default_nettype wire

// ----- hdl/sha1_byte_stream_hasher_unit.sv -----
// Top level of the SHA-1 byte stream hasher: byte packing, padding sequencer,
// message schedule and chaining state. Depends on sha1bs_pkg and sha1bs_round.
`default_nettype none

// Message bytes are taken one per cycle while idle, shifted big-endian into a
// 16-word block buffer. Every 64th byte starts the compression, which runs
// one round per cycle through a single round unit over all rounds and then
// adds the working words into the chaining state. A finish request shifts
// in the 0x80 pad, zero fill and the bit length one byte per cycle,
// compresses, and repeats this with a second block when fewer than 9 bytes
// were free. The five digest words then leave H0 first, one per accepted
// output word. No input is taken while a compression, padding or digest
// output is in progress.
module sha1_byte_stream_hasher_unit (
	input  var logic        clk,
	input  var logic        arst_n,
	input  var logic        in_valid,
	output var logic        in_stall,
	input  var logic        req_type,
	input  var logic [7:0]  data_byte,
	output var logic        out_valid,
	input  var logic        out_stall,
	output var logic [31:0] digest_word,
	output var logic [2:0]  word_index,
	output var logic        last_word
);
	import sha1bs_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]   state_q;
	logic [2:0]   ret_q;
	logic [31:0]  h_q [5];
	logic [31:0]  w_q [16];
	logic [60:0]  count_q;
	logic [63:0]  bits_q;
	logic [5:0]   pos_q;
	logic         first_q;
	logic         extra_q;
	logic [6:0]   rnd_q;
	logic [2:0]   out_idx_q;
	sha1bs_work_t work_q;
	sha1bs_work_t work_next;
	sha1bs_work_t work_init;
	logic         in_acc;
	logic         out_acc;
	logic         shift_byte;
	logic [7:0]   byte_in;
	logic         len_byte;
	logic [31:0]  sched_new;
	logic [31:0]  sched_x;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign out_acc = out_valid && !out_stall;

	assign work_init = '{a: h_q[0], b: h_q[1], c: h_q[2], d: h_q[3], e: h_q[4]};

	sha1bs_round u_round (
		.cur (work_q),
		.wt  (w_q[0]),
		.rnd (rnd_q),
		.nxt (work_next)
	);

	assign sched_x = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign sched_new = {sched_x[30:0], sched_x[31]};

	always_comb begin
		len_byte = (pos_q >= 6'd56) && !extra_q;
		if (state_q == ST_PAD) begin
			shift_byte = 1'b1;
			if (first_q) begin
				byte_in = PAD_BYTE;
			end else if (len_byte) begin
				byte_in = bits_q[63:56];
			end else begin
				byte_in = 8'h00;
			end
		end else begin
			shift_byte = in_acc && !req_type;
			byte_in = data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_byte) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], byte_in};
		end else if (state_q == ST_COMP) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= sched_new;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_COMP) begin
			work_q <= work_next;
		end else if ((shift_byte && state_q == ST_IDLE && count_q[5:0] == 6'd63)
				|| (state_q == ST_PAD && pos_q == 6'd63)) begin
			work_q <= work_init;
		end
		if (in_acc && req_type) begin
			bits_q <= {count_q, 3'b000};
		end else if (state_q == ST_PAD && !first_q && len_byte) begin
			bits_q <= {bits_q[55:0], 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			count_q <= '0;
			pos_q <= '0;
			first_q <= 1'b0;
			extra_q <= 1'b0;
			rnd_q <= '0;
			out_idx_q <= '0;
			for (int i = 0; i < 5; i++) begin
				h_q[i] <= H_INIT[i];
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (req_type) begin
							pos_q <= count_q[5:0];
							first_q <= 1'b1;
							extra_q <= (count_q[5:0] >= 6'd56);
							count_q <= '0;
							state_q <= ST_PAD;
						end else begin
							count_q <= count_q + 61'd1;
							if (count_q[5:0] == 6'd63) begin
								rnd_q <= '0;
								ret_q <= ST_IDLE;
								state_q <= ST_COMP;
							end
						end
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					pos_q <= pos_q + 6'd1;
					if (pos_q == 6'd63) begin
						rnd_q <= '0;
						state_q <= ST_COMP;
						extra_q <= 1'b0;
						ret_q <= extra_q ? ST_PAD : ST_OUT;
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + work_q.a;
					h_q[1] <= h_q[1] + work_q.b;
					h_q[2] <= h_q[2] + work_q.c;
					h_q[3] <= h_q[3] + work_q.d;
					h_q[4] <= h_q[4] + work_q.e;
					out_idx_q <= '0;
					state_q <= ret_q;
				end
				ST_OUT: begin
					if (out_acc) begin
						if (out_idx_q == LAST_WORD_IDX) begin
							for (int i = 0; i < 5; i++) begin
								h_q[i] <= H_INIT[i];
							end
							state_q <= ST_IDLE;
						end else begin
							out_idx_q <= out_idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		case (out_idx_q)
			3'd0: digest_word = h_q[0];
			3'd1: digest_word = h_q[1];
			3'd2: digest_word = h_q[2];
			3'd3: digest_word = h_q[3];
			default: digest_word = h_q[4];
		endcase
	end

	assign word_index = out_idx_q;
	assign last_word = (out_idx_q == LAST_WORD_IDX);

endmodule

`default_nettype wire

// ----- test/sha1bs_tb_pkg.sv -----
// Request codes shared by the SHA-1 hasher testbench top and its checker.
// Depends on nothing.
package sha1bs_tb_pkg;

	typedef enum logic {
		REQ_ABSORB = 1'b0,
		REQ_FINISH = 1'b1
	} sha1bs_req_t;

endpackage

// ----- test/sha1_stream_checker.sv -----
// Checker for the SHA-1 byte stream hasher: watches both channels, keeps its own SHA-1
// state and compares every digest word leaving the block. Depends on sha1bs_tb_pkg.
module sha1_stream_checker (
	input  var logic        clk,
	input  var logic        arst_n,
	input  var logic        in_valid,
	input  var logic        in_stall,
	input  var logic        req_type,
	input  var logic [7:0]  data_byte,
	input  var logic        out_valid,
	input  var logic        out_stall,
	input  var logic [31:0] digest_word,
	input  var logic [2:0]  word_index,
	input  var logic        last_word,
	output int              mismatch_count,
	output int              expected_left,
	output int              digests_checked
);
	import sha1bs_tb_pkg::*;

	localparam logic [31:0] INIT_H [5] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};
	localparam logic [31:0] ROUND_K [4] = '{
		32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
	};
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam int DIGEST_WORDS = 5;

	typedef struct {
		logic [31:0] value;
		logic [2:0]  idx;
		logic        fin;
	} digest_entry_t;

	logic [31:0] hash_h [5];
	logic [31:0] blk [16];
	logic [60:0] nbytes;
	digest_entry_t digest_q [$];
	digest_entry_t head;
	int n_mismatch = 0;
	int n_left = 0;
	int n_checked = 0;

	assign mismatch_count = n_mismatch;
	assign expected_left = n_left;
	assign digests_checked = n_checked;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void put_byte(input int pos, input logic [7:0] v);
		blk[pos / 4][(3 - pos % 4) * 8 +: 8] = v;
	endfunction

	function automatic void compress_block();
		logic [31:0] w [16];
		logic [31:0] va, vb, vc, vd, ve, fval, sum;
		int s;
		w = blk;
		va = hash_h[0];
		vb = hash_h[1];
		vc = hash_h[2];
		vd = hash_h[3];
		ve = hash_h[4];
		for (int r = 0; r < 80; r++) begin
			s = r % 16;
			if (r >= 16) begin
				w[s] = rotl(w[(s + 13) % 16] ^ w[(s + 8) % 16] ^ w[(s + 2) % 16] ^ w[s], 1);
			end
			if (r < 20) begin
				fval = (vb & vc) | (~vb & vd);
			end else if (r < 40 || r >= 60) begin
				fval = vb ^ vc ^ vd;
			end else begin
				fval = (vb & vc) ^ (vb & vd) ^ (vc & vd);
			end
			sum = rotl(va, 5) + fval + ve + w[s] + ROUND_K[r / 20];
			ve = vd;
			vd = vc;
			vc = rotl(vb, 30);
			vb = va;
			va = sum;
		end
		hash_h[0] += va;
		hash_h[1] += vb;
		hash_h[2] += vc;
		hash_h[3] += vd;
		hash_h[4] += ve;
	endfunction

	function automatic void hash_restart();
		for (int i = 0; i < DIGEST_WORDS; i++) begin
			hash_h[i] = INIT_H[i];
		end
		nbytes = '0;
	endfunction

	function automatic void take_request(input sha1bs_req_t kind, input logic [7:0] value);
		int fill;
		logic [63:0] bit_len;
		digest_entry_t e;
		fill = int'(nbytes[5:0]);
		if (kind == REQ_ABSORB) begin
			put_byte(fill, value);
			nbytes = nbytes + 1'b1;
			if (fill == 63) begin
				compress_block();
			end
			return;
		end
		put_byte(fill, PAD_MARK);
		for (int i = fill + 1; i < 64; i++) begin
			put_byte(i, 8'h00);
		end
		if (fill >= 56) begin
			compress_block();
			for (int i = 0; i < 14; i++) begin
				blk[i] = '0;
			end
		end
		bit_len = {nbytes, 3'b000};
		blk[14] = bit_len[63:32];
		blk[15] = bit_len[31:0];
		compress_block();
		for (int i = 0; i < DIGEST_WORDS; i++) begin
			e.value = hash_h[i];
			e.idx = 3'(i);
			e.fin = (i == DIGEST_WORDS - 1);
			digest_q.push_back(e);
		end
		hash_restart();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_restart();
			for (int i = 0; i < 16; i++) begin
				blk[i] = '0;
			end
			digest_q.delete();
		end else begin
			if (in_valid && !in_stall) begin
				take_request(sha1bs_req_t'(req_type), data_byte);
			end
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					n_mismatch++;
					$display("%0t: unexpected digest word %h index %0d, nothing pending",
						$time, digest_word, word_index);
				end else begin
					head = digest_q.pop_front();
					n_checked++;
					if (digest_word !== head.value) begin
						n_mismatch++;
						$display("%0t: digest_word expected %h got %h",
							$time, head.value, digest_word);
					end
					if (word_index !== head.idx) begin
						n_mismatch++;
						$display("%0t: word_index expected %0d got %0d",
							$time, head.idx, word_index);
					end
					if (last_word !== head.fin) begin
						n_mismatch++;
						$display("%0t: last_word expected %b got %b",
							$time, head.fin, last_word);
					end
				end
			end
		end
		n_left = digest_q.size();
	end

endmodule

// ----- test/sha1_byte_stream_hasher_unit_tb.sv -----
// Testbench top for the SHA-1 byte stream hasher: clock, reset, message stimulus and
// output back-pressure. Depends on sha1bs_tb_pkg, sha1_stream_checker and the block itself.
module sha1_byte_stream_hasher_unit_tb;
	import sha1bs_tb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        req_type;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	int          mismatch_count;
	int          expected_left;
	int          digests_checked;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int long_hold_cycles = 0;
	int words_sent = 0;
	int finishes_sent = 0;
	int phase = 1;
	int wait_cycles;
	int msg_len;

	sha1_byte_stream_hasher_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	sha1_stream_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// The long hold-off is counted down here while the sender keeps offering words.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_cycles > 0) begin
				out_stall <= 1'b1;
				long_hold_cycles--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	task automatic send_word(input sha1bs_req_t kind, input logic [7:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			req_type <= 1'($urandom);
			data_byte <= 8'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		data_byte <= value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
		if (kind == REQ_FINISH) begin
			finishes_sent++;
		end
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) begin
			send_word(REQ_ABSORB, 8'($urandom_range(255)));
		end
		send_word(REQ_FINISH, 8'($urandom_range(255)));
	endtask

	function automatic int pick_length();
		int sel;
		sel = $urandom_range(99);
		if (sel < 55) begin
			return $urandom_range(6);
		end
		if (sel < 80) begin
			case ($urandom_range(5))
				0: return 55;
				1: return 56;
				2: return 63;
				3: return 64;
				4: return 119;
				default: return 120;
			endcase
		end
		return $urandom_range(20);
	endfunction

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= REQ_ABSORB;
		data_byte <= 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 24;
		recv_idle_pct = 74;

		// Empty message, extreme byte values, a repeated empty message and "abc".
		send_word(REQ_FINISH, 8'h00);
		send_word(REQ_ABSORB, 8'h00);
		send_word(REQ_ABSORB, 8'hff);
		send_word(REQ_FINISH, 8'h00);
		send_word(REQ_FINISH, 8'hff);
		send_word(REQ_ABSORB, 8'h61);
		send_word(REQ_ABSORB, 8'h62);
		send_word(REQ_ABSORB, 8'h63);
		send_word(REQ_FINISH, 8'h00);

		while (words_sent < 260) begin
			if (phase == 1 && words_sent >= 100) begin
				phase = 2;
				send_idle_pct = 74;
				recv_idle_pct = 24;
			end else if (phase == 2 && words_sent >= 180) begin
				phase = 3;
				send_idle_pct = 0;
				recv_idle_pct = 0;
				long_hold_cycles = 500;
			end
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(12, 1)) begin
					send_word(($urandom_range(3) == 0) ? REQ_FINISH : REQ_ABSORB,
						8'($urandom_range(255)));
				end
			end else begin
				msg_len = pick_length();
				if (msg_len > 259 - words_sent) begin
					msg_len = 259 - words_sent;
				end
				send_message(msg_len);
			end
		end
		send_word(REQ_FINISH, 8'($urandom_range(255)));
		in_valid <= 1'b0;
		@(posedge clk);

		wait_cycles = 0;
		while (expected_left != 0 && wait_cycles < 50000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (200) @(posedge clk);

		$display("Sent %0d input words including %0d finish requests; checked %0d digest words.",
			words_sent, finishes_sent, digests_checked);
		$display("Covered sender-heavy, receiver-heavy and no-idle phases plus a long output hold.");
		if (mismatch_count == 0 && expected_left == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/sha1bs_pkg.sv
hdl/sha1bs_round.sv
hdl/sha1_byte_stream_hasher_unit.sv
test/sha1bs_tb_pkg.sv
test/sha1_stream_checker.sv
test/sha1_byte_stream_hasher_unit_tb.sv
